@@ design/avd_pkg.sv @@
// avd_pkg: shared types, codes and tables for the adpcm voice decoder
// no dependencies; imported by avd_ctrl, avd_decode, adpcm_voice_decoder and the bench

package avd_pkg;

	localparam int SIG_W   = 16;
	localparam int STEP_W  = 15;
	localparam int POS_W   = 16;
	localparam int INC_W   = 20;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 3;

	localparam logic [STEP_W-1:0] STEP_MIN = 15'h007f;
	localparam logic [STEP_W-1:0] STEP_MAX = 15'h6000;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_KEY_ON = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_START  = 3'd0,
		REG_LOOP_END    = 3'd1,
		REG_LOOP_ENABLE = 3'd2,
		REG_KEY_HELD    = 3'd3,
		REG_RESTORE     = 3'd4,
		REG_PHASE_INC   = 3'd5
	} cfg_reg_t;

	// per-item control decided at acceptance, carried down the pipeline
	typedef struct packed {
		logic tick;     // item produces a result
		logic live;     // voice was playing when the tick arrived
		logic key_on;
		logic odd;      // low nibble of the byte
		logic save;     // capture signal/step as the loop pair
		logic restore;  // reload the loop pair after this tick
		logic looped;
		logic playing;  // voice still playing after this item
	} avd_ctl_t;

	// magnitude of the difference multiplier: 1, 3, 5 .. 15
	function automatic logic [3:0] diff_mag(input logic [2:0] code);
		return {code, 1'b1};
	endfunction

	function automatic logic [9:0] step_scale(input logic [2:0] code);
		logic [9:0] s;
		case (code)
			3'd4:    s = 10'h133;
			3'd5:    s = 10'h199;
			3'd6:    s = 10'h200;
			3'd7:    s = 10'h266;
			default: s = 10'h0e6;
		endcase
		return s;
	endfunction

endpackage

@@ design/avd_sample_ram.sv @@
// avd_sample_ram: byte-wide synchronous sample memory, one access per cycle
// registered read data, updated only on a read; no dependencies

module avd_sample_ram #(
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ design/avd_ctrl.sv @@
// avd_ctrl: phase accumulator and loop/stop control, updated when an item is accepted
// uses avd_pkg; feeds per-item control to the decode pipeline

module avd_ctrl #(
	parameter int PHASE_FRAC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            operation,
	input  logic [15:0]           loop_start,
	input  logic [15:0]           loop_end,
	input  logic                  loop_enable,
	input  logic                  key_held,
	input  logic                  restore_at_loop,
	input  logic [19:0]           phase_increment,
	output avd_pkg::avd_ctl_t     ctl,
	output logic [15:0]           pos
);

	import avd_pkg::*;

	localparam int PW = POS_W + PHASE_FRAC_BITS;

	logic [PW-1:0]    phase_q;
	logic             has_looped_q;
	logic             playing_q;

	logic [PW-1:0]    phase_sum;
	logic [PW-1:0]    restart_phase;
	logic [POS_W-1:0] new_pos;
	logic             at_end;
	logic             do_loop;

	assign pos           = phase_q[PW-1:PHASE_FRAC_BITS];
	assign phase_sum     = phase_q + PW'(phase_increment);
	assign new_pos       = phase_sum[PW-1:PHASE_FRAC_BITS];
	assign restart_phase = {loop_start, {PHASE_FRAC_BITS{1'b0}}};
	assign at_end        = (new_pos >= loop_end);
	assign do_loop       = at_end && loop_enable && key_held;

	always_comb begin
		ctl = '0;
		case (op_t'(operation))
			OP_KEY_ON: begin
				ctl.key_on = 1'b1;
			end
			OP_TICK: begin
				ctl.tick = 1'b1;
				ctl.live = playing_q;
				ctl.odd  = pos[0];
				if (playing_q) begin
					ctl.save    = loop_enable && (new_pos == loop_start) && !has_looped_q;
					ctl.looped  = do_loop;
					ctl.restore = do_loop && restore_at_loop;
					ctl.playing = !(at_end && !do_loop);
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			has_looped_q <= 1'b0;
			playing_q    <= 1'b0;
		end else if (accept) begin
			case (op_t'(operation))
				OP_KEY_ON: begin
					phase_q      <= restart_phase;
					has_looped_q <= 1'b0;
					playing_q    <= 1'b1;
				end
				OP_TICK: begin
					if (playing_q) begin
						phase_q <= do_loop ? restart_phase : phase_sum;
						if (do_loop) begin
							has_looped_q <= 1'b1;
						end
						if (at_end && !do_loop) begin
							playing_q <= 1'b0;
						end
					end
				end
				default: begin
					playing_q <= playing_q;
				end
			endcase
		end
	end

endmodule

@@ design/avd_decode.sv @@
// avd_decode: adpcm arithmetic with predicted signal, adaptive step and the loop pair
// uses avd_pkg; takes the registered byte from avd_sample_ram

module avd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  avd_pkg::avd_ctl_t   ctl,
	input  logic [7:0]          byte_data,
	output logic signed [15:0]  sample
);

	import avd_pkg::*;

	logic signed [SIG_W-1:0] sig_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [SIG_W-1:0] saved_sig_q;
	logic [STEP_W-1:0]       saved_step_q;

	logic [3:0]              nib;
	logic [18:0]             mag;
	logic [15:0]             delta;
	logic signed [17:0]      sig_ext;
	logic signed [17:0]      sum;
	logic signed [SIG_W-1:0] sig_new;
	logic [24:0]             step_prod;
	logic [16:0]             step_shift;
	logic [STEP_W-1:0]       step_new;
	logic signed [SIG_W-1:0] saved_sig_nx;
	logic [STEP_W-1:0]       saved_step_nx;

	assign nib = ctl.odd ? byte_data[3:0] : byte_data[7:4];

	// step*diff/8 toward zero: shift the magnitude, then apply the sign
	assign mag     = {4'b0, step_q} * {15'b0, diff_mag(nib[2:0])};
	assign delta   = mag[18:3];
	assign sig_ext = {{2{sig_q[SIG_W-1]}}, sig_q};
	assign sum     = nib[3] ? (sig_ext - $signed({2'b0, delta}))
	                        : (sig_ext + $signed({2'b0, delta}));

	always_comb begin
		if (sum < -18'sd32768) begin
			sig_new = 16'sh8000;
		end else if (sum > 18'sd32767) begin
			sig_new = 16'sh7fff;
		end else begin
			sig_new = sum[SIG_W-1:0];
		end
	end

	assign step_prod  = {10'b0, step_q} * {15'b0, step_scale(nib[2:0])};
	assign step_shift = step_prod[24:8];

	always_comb begin
		if (step_shift < 17'(STEP_MIN)) begin
			step_new = STEP_MIN;
		end else if (step_shift > 17'(STEP_MAX)) begin
			step_new = STEP_MAX;
		end else begin
			step_new = step_shift[STEP_W-1:0];
		end
	end

	// a save on this tick is seen by a restore on the same tick
	assign saved_sig_nx  = ctl.save ? sig_new : saved_sig_q;
	assign saved_step_nx = ctl.save ? step_new : saved_step_q;

	assign sample = ctl.live ? sig_new : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q        <= '0;
			step_q       <= STEP_MIN;
			saved_sig_q  <= '0;
			saved_step_q <= STEP_MIN;
		end else if (en) begin
			if (ctl.key_on) begin
				sig_q        <= '0;
				step_q       <= STEP_MIN;
				saved_sig_q  <= '0;
				saved_step_q <= STEP_MIN;
			end else if (ctl.tick && ctl.live) begin
				saved_sig_q  <= saved_sig_nx;
				saved_step_q <= saved_step_nx;
				sig_q        <= ctl.restore ? saved_sig_nx : sig_new;
				step_q       <= ctl.restore ? saved_step_nx : step_new;
			end
		end
	end

endmodule

@@ design/adpcm_voice_decoder.sv @@
// adpcm_voice_decoder: one 4-bit adpcm voice playing from an internal sample memory
// uses avd_pkg, avd_sample_ram, avd_ctrl and avd_decode
//
// Usage:
//  Input channel (in_valid/in_stall) carries operation, byte_address, byte_value.
//  A write transaction stores one byte, a key-on transaction restarts playback at
//  loop_start, a tick transaction yields one result on the output channel
//  (out_valid/out_stall): sample_out, voice_playing, looped_now. Other items give
//  no result.
//  Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index and
//  cfg_data; the user must make them only while the block is idle, and the block
//  itself does not enforce this. Throughput: one item per cycle while no result
//  is stalled. The phase update closes at acceptance, the signal/step update in
//  the decode stage, and each tick on a playing voice needs one access of the
//  single-port sample memory. A tick result passes address reduction, memory read
//  and then decode into the output register, each registered in turn.
//  When the receiver stalls a waiting result, the whole pipeline holds and in_stall
//  is raised until that result is taken.
//  Reset clears the pipeline and the voice (stopped, signal 0, step 0x7f) and loads
//  the register defaults; the sample memory is not cleared and must be written
//  before it is played.

module adpcm_voice_decoder #(
	parameter int MEM_BYTES       = 32768,
	parameter int PHASE_FRAC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	input  logic [14:0]         byte_address,
	input  logic [7:0]          byte_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  sample_out,
	output logic                voice_playing,
	output logic                looped_now,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [19:0]         cfg_data
);

	import avd_pkg::*;

	localparam int AW        = $clog2(MEM_BYTES);
	localparam int MOD_SHIFT = 15;
	localparam int RECIP     = (1 << MOD_SHIFT) / MEM_BYTES;

	// configuration registers
	logic [15:0]      loop_start_q;
	logic [15:0]      loop_end_q;
	logic             loop_enable_q;
	logic             key_held_q;
	logic             restore_q;
	logic [INC_W-1:0] phase_inc_q;

	logic             adv;
	logic             accept;
	avd_ctl_t         ctl_a;
	logic [15:0]      pos_a;
	logic [22:0]      quot_prod;
	logic             wr_ok;

	logic             valid_s1;
	avd_ctl_t         ctl_s1;
	logic [14:0]      byte_idx_s1;
	logic [7:0]       quot_s1;
	logic             wr_s1;
	logic [AW-1:0]    waddr_s1;
	logic [7:0]       wdata_s1;

	logic [23:0]      quot_mul;
	logic [16:0]      rem;
	logic [16:0]      rem_fix;
	logic [AW-1:0]    rd_addr;
	logic             ram_en;
	logic [AW-1:0]    ram_addr;
	logic [7:0]       ram_rdata;

	logic             valid_s2;
	avd_ctl_t         ctl_s2;
	logic signed [15:0] dec_sample;

	logic             out_valid_q;
	logic signed [15:0] sample_q;
	logic             playing_q;
	logic             looped_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_start_q  <= 16'd0;
			loop_end_q    <= 16'hffff;
			loop_enable_q <= 1'b0;
			key_held_q    <= 1'b0;
			restore_q     <= 1'b1;
			phase_inc_q   <= 20'd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOOP_START:  loop_start_q  <= cfg_data[15:0];
				REG_LOOP_END:    loop_end_q    <= cfg_data[15:0];
				REG_LOOP_ENABLE: loop_enable_q <= cfg_data[0];
				REG_KEY_HELD:    key_held_q    <= cfg_data[0];
				REG_RESTORE:     restore_q     <= cfg_data[0];
				REG_PHASE_INC:   phase_inc_q   <= cfg_data[INC_W-1:0];
				default: begin
					loop_start_q <= loop_start_q;
				end
			endcase
		end
	end

	// pipeline moves as one unless a result is waiting on a stalled receiver
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	avd_ctrl #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.operation       (operation),
		.loop_start      (loop_start_q),
		.loop_end        (loop_end_q),
		.loop_enable     (loop_enable_q),
		.key_held        (key_held_q),
		.restore_at_loop (restore_q),
		.phase_increment (phase_inc_q),
		.ctl             (ctl_a),
		.pos             (pos_a)
	);

	// byte index mod MEM_BYTES: reciprocal estimate here, one correction in stage 1
	assign quot_prod = {8'b0, pos_a[15:1]} * 23'(RECIP);
	assign wr_ok     = ({1'b0, byte_address} < 16'(MEM_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1      <= ctl_a;
			byte_idx_s1 <= pos_a[15:1];
			quot_s1     <= quot_prod[22:MOD_SHIFT];
			wr_s1       <= (op_t'(operation) == OP_WRITE) && wr_ok;
			waddr_s1    <= byte_address[AW-1:0];
			wdata_s1    <= byte_value;
			ctl_s2      <= ctl_s1;
		end
	end

	assign quot_mul = {16'b0, quot_s1} * 24'(MEM_BYTES);
	assign rem      = {2'b0, byte_idx_s1} - quot_mul[16:0];
	assign rem_fix  = (rem >= 17'(MEM_BYTES)) ? (rem - 17'(MEM_BYTES)) : rem;
	assign rd_addr  = rem_fix[AW-1:0];

	assign ram_en   = adv && valid_s1 && (wr_s1 || (ctl_s1.tick && ctl_s1.live));
	assign ram_addr = wr_s1 ? waddr_s1 : rd_addr;

	avd_sample_ram #(
		.DEPTH(MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (wr_s1),
		.addr  (ram_addr),
		.wdata (wdata_s1),
		.rdata (ram_rdata)
	);

	avd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv && valid_s2),
		.ctl       (ctl_s2),
		.byte_data (ram_rdata),
		.sample    (dec_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2 && ctl_s2.tick;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_q  <= dec_sample;
			playing_q <= ctl_s2.playing;
			looped_q  <= ctl_s2.looped;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_out    = sample_q;
	assign voice_playing = playing_q;
	assign looped_now    = looped_q;

	a_loop_keeps_playing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && looped_now |-> voice_playing)
		else $error("loop transaction reported a stopped voice");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input held off with no result waiting");

	a_stopped_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ctl_s2.tick && !ctl_s2.live |->
			!ctl_s2.playing && !ctl_s2.looped && !ctl_s2.save && !ctl_s2.restore)
		else $error("tick on a stopped voice changed loop state");

endmodule

@@ sim/tb_adpcm_voice_decoder.sv @@
`timescale 1ns / 100ps
// tb_adpcm_voice_decoder: self-checking bench for the adpcm voice decoder
// depends on avd_pkg and adpcm_voice_decoder; a behavioral voice model predicts every sample

module tb_adpcm_voice_decoder;
	import avd_pkg::*;

	localparam int FRAC           = 12;
	localparam int STEP_FLOOR     = 'h7f;
	localparam int STEP_CEIL      = 'h6000;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int STYLE_ANY      = 0;
	localparam int STYLE_RISE     = 1;
	localparam int STYLE_FALL     = 2;
	localparam int STYLE_QUIET    = 3;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_TAIL      = 8;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               playing;
		logic               looped;
	} voice_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic [14:0]        byte_address;
	logic [7:0]         byte_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] sample_out;
	logic               voice_playing;
	logic               looped_now;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [19:0]        cfg_data;

	// voice model state
	logic [27:0] voice_phase = '0;
	int          voice_sig   = 0;
	int          voice_step  = STEP_FLOOR;
	int          saved_sig   = 0;
	int          saved_step  = STEP_FLOOR;
	bit          looped_once = 1'b0;
	bit          voice_on    = 1'b0;
	logic [7:0]  voice_mem [32768];
	bit          written [32768];

	logic [15:0] cfg_loop_start = 16'h0000;
	logic [15:0] cfg_loop_end   = 16'hffff;
	bit          cfg_loop_en    = 1'b0;
	bit          cfg_key        = 1'b0;
	bit          cfg_restore    = 1'b1;
	logic [19:0] cfg_inc        = 20'd4096;

	voice_result_t pending_samples [$];
	int mismatches   = 0;
	int quiet_cycles = 0;
	bit in_gaps  = 1'b1;
	bit out_gaps = 1'b1;
	bit hold_req = 1'b0;

	adpcm_voice_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.byte_address(byte_address),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.voice_playing(voice_playing),
		.looped_now(looped_now),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int step_factor(input logic [2:0] code);
		case (code)
			3'd4:    return 'h133;
			3'd5:    return 'h199;
			3'd6:    return 'h200;
			3'd7:    return 'h266;
			default: return 'h0e6;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte(input int style);
		logic [7:0] r;
		r = 8'($urandom);
		case (style)
			STYLE_RISE:  r = (r & 8'h33) | 8'h44;
			STYLE_FALL:  r = (r & 8'h33) | 8'hcc;
			STYLE_QUIET: r = r & 8'h99;
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t: %s is %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic advance_voice(input logic [1:0] op, input logic [14:0] addr,
			input logic [7:0] val);
		voice_result_t r;
		logic [15:0] pos;
		logic [15:0] next_pos;
		logic [7:0]  b;
		logic [3:0]  nib;
		int          delta;
		case (op)
			OP_WRITE: begin
				voice_mem[addr] = val;
				written[addr] = 1'b1;
			end
			OP_KEY_ON: begin
				voice_phase = {cfg_loop_start, {FRAC{1'b0}}};
				voice_sig = 0;
				voice_step = STEP_FLOOR;
				saved_sig = 0;
				saved_step = STEP_FLOOR;
				looped_once = 1'b0;
				voice_on = 1'b1;
			end
			OP_TICK: begin
				r = '0;
				if (voice_on) begin
					pos = voice_phase[FRAC +: 16];
					b = voice_mem[pos[15:1]];
					nib = pos[0] ? b[3:0] : b[7:4];
					delta = (voice_step * (2 * int'(nib[2:0]) + 1)) / 8;
					if (nib[3])
						delta = -delta;
					voice_sig = clamp_int(voice_sig + delta, -32768, 32767);
					voice_step = clamp_int((voice_step * step_factor(nib[2:0])) >> 8,
						STEP_FLOOR, STEP_CEIL);
					r.sample = voice_sig[15:0];
					voice_phase = voice_phase + 28'(cfg_inc);
					next_pos = voice_phase[FRAC +: 16];
					// loop pair captured on the first pass, before the end test
					if (cfg_loop_en && next_pos == cfg_loop_start && !looped_once) begin
						saved_sig = voice_sig;
						saved_step = voice_step;
					end
					if (next_pos >= cfg_loop_end) begin
						if (cfg_loop_en && cfg_key) begin
							voice_phase = {cfg_loop_start, {FRAC{1'b0}}};
							if (cfg_restore) begin
								voice_sig = saved_sig;
								voice_step = saved_step;
							end
							looped_once = 1'b1;
							r.looped = 1'b1;
						end else begin
							voice_on = 1'b0;
						end
					end
					r.playing = voice_on;
				end
				pending_samples.push_back(r);
			end
			default: ;
		endcase
	endtask

	// entered and left at a falling edge
	task automatic offer_item(input logic [1:0] op, input logic [14:0] addr,
			input logic [7:0] val);
		if (in_gaps && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		byte_address <= addr;
		byte_value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_voice(op, addr, val);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(negedge clk);
		// writes and key-ons may still be in flight
		repeat (IDLE_TAIL) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_LOOP_START:  cfg_loop_start = value[15:0];
			REG_LOOP_END:    cfg_loop_end = value[15:0];
			REG_LOOP_ENABLE: cfg_loop_en = value[0];
			REG_KEY_HELD:    cfg_key = value[0];
			REG_RESTORE:     cfg_restore = value[0];
			REG_PHASE_INC:   cfg_inc = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_voice(input logic [15:0] start_pos, input logic [15:0] end_pos,
			input bit loop_en, input bit key, input bit restore_en, input logic [19:0] inc);
		logic [18:0] junk;
		wait_idle();
		// bits above a register's width are don't-care
		junk = ($urandom_range(3) == 0) ? 19'($urandom) : 19'h0;
		write_reg(REG_LOOP_START, {junk[3:0], start_pos});
		write_reg(REG_LOOP_END, {junk[18:15], end_pos});
		write_reg(REG_LOOP_ENABLE, {junk, loop_en});
		write_reg(REG_KEY_HELD, {junk, key});
		write_reg(REG_RESTORE, {junk, restore_en});
		write_reg(REG_PHASE_INC, inc);
	endtask

	task automatic send_tick(input int style);
		logic [14:0] b;
		b = voice_phase[FRAC+1 +: 15];
		// never play a byte that was not written
		if (voice_on && !written[b])
			offer_item(OP_WRITE, b, pick_byte(style));
		offer_item(OP_TICK, 15'($urandom), 8'($urandom));
	endtask

	task automatic play_items(input int count, input int style);
		int          roll;
		logic [14:0] a;
		repeat (count) begin
			roll = $urandom_range(99);
			a = $urandom_range(1) ? 15'($urandom)
				: voice_phase[FRAC+1 +: 15] + 15'($urandom_range(3));
			if (roll < 6 || (!voice_on && roll < 40))
				offer_item(OP_KEY_ON, a, 8'($urandom));
			else if (roll < 16)
				offer_item(OP_WRITE, a, pick_byte(style));
			else if (roll < 18)
				offer_item(OP_UNUSED, a, 8'($urandom));
			else
				send_tick(style);
		end
	endtask

	task automatic test_stopped_voice();
		write_reg(REG_SPARE_A, 20'($urandom));
		write_reg(REG_SPARE_B, 20'($urandom));
		offer_item(OP_TICK, 15'h7fff, 8'hff);
		offer_item(OP_UNUSED, 15'h0000, 8'h00);
		offer_item(OP_WRITE, 15'h7fff, 8'ha5);
	endtask

	task automatic test_decode_basic();
		program_voice(16'h0000, 16'hffff, 1'b0, 1'b0, 1'b1, 20'd4096);
		offer_item(OP_WRITE, 15'h0000, 8'h7f);
		offer_item(OP_WRITE, 15'h0001, 8'h80);
		offer_item(OP_WRITE, 15'h0002, 8'h34);
		offer_item(OP_KEY_ON, 15'h0000, 8'h00);
		repeat (6) send_tick(STYLE_ANY);
	endtask

	task automatic test_stop_at_end();
		program_voice(16'h0000, 16'h0004, 1'b1, 1'b0, 1'b1, 20'd4096);
		offer_item(OP_KEY_ON, 15'h0000, 8'h00);
		repeat (5) send_tick(STYLE_ANY);
	endtask

	task automatic test_loop_restore();
		program_voice(16'h0000, 16'hffff, 1'b1, 1'b1, 1'b1, 20'd4096);
		offer_item(OP_KEY_ON, 15'h0000, 8'h00);
		// loop start moved ahead of the play position so the pair gets captured
		program_voice(16'h0002, 16'h0004, 1'b1, 1'b1, 1'b1, 20'd4096);
		repeat (6) send_tick(STYLE_ANY);
		program_voice(16'h0002, 16'h0004, 1'b1, 1'b1, 1'b0, 20'd4096);
		repeat (3) send_tick(STYLE_ANY);
	endtask

	task automatic test_random_play();
		logic [15:0] start_pos;
		logic [15:0] end_pos;
		logic [19:0] inc;
		int          style;
		int          p;
		for (p = 0; p < 12; p++) begin
			start_pos = 16'($urandom);
			end_pos = start_pos + 16'($urandom_range(64, 2));
			inc = 20'($urandom_range(12288, 512));
			if (p % 3 == 2) begin
				case (p / 3)
					0: begin
						start_pos = 16'h0000;
						end_pos = 16'hffff;
						inc = 20'hfffff;
					end
					1: begin
						start_pos = 16'hffff;
						end_pos = 16'h0000;
						inc = 20'h00000;
					end
					2: inc = 20'h00001;
					default: begin
						start_pos = 16'h0000;
						end_pos = 16'h0000;
						inc = 20'($urandom);
					end
				endcase
			end
			style = $urandom_range(3);
			// one long run with neither side idling
			in_gaps = (p != 4);
			out_gaps = (p != 4);
			program_voice(start_pos, end_pos, $urandom_range(99) < 75,
				$urandom_range(99) < 80, 1'($urandom_range(1)), inc);
			if ($urandom_range(1))
				offer_item(OP_KEY_ON, 15'($urandom), 8'($urandom));
			play_items(70, style);
		end
		in_gaps = 1'b1;
		out_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		program_voice(16'h0100, 16'h0140, 1'b1, 1'b1, 1'b1, 20'd6144);
		offer_item(OP_KEY_ON, 15'h0000, 8'h00);
		// receiver holds off while items keep coming, so the pipe fills
		hold_req = 1'b1;
		play_items(150, STYLE_ANY);
	endtask

	// receiver side
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_stall <= out_gaps && ($urandom_range(99) < 15);
		end
	end

	always @(posedge clk) begin : check_samples
		voice_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				flag_mismatch("result with none pending, sample_out", sample_out, 0);
			end else begin
				want = pending_samples.pop_front();
				if (sample_out !== want.sample)
					flag_mismatch("sample_out", sample_out, want.sample);
				if (voice_playing !== want.playing)
					flag_mismatch("voice_playing", voice_playing, want.playing);
				if (looped_now !== want.looped)
					flag_mismatch("looped_now", looped_now, want.looped);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_adpcm_voice_decoder NOT OK");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		operation = OP_WRITE;
		byte_address = '0;
		byte_value = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_stopped_voice();
		test_decode_basic();
		test_stop_at_end();
		test_loop_restore();
		test_random_play();
		test_backpressure();
		wait_idle();
		if (mismatches == 0)
			$display("tb_adpcm_voice_decoder OK");
		else
			$display("tb_adpcm_voice_decoder NOT OK");
		$finish;
	end

endmodule
